// ===== rtl/pcxrle_pkg.sv =====
// shared types and constants for the pcx run-length scanline decoder
package pcxrle_pkg;

   // field widths fixed by the stream format
   localparam int ADDR_W  = 26;
   localparam int BYTE_W  = 8;
   localparam int CFG_W   = 13;
   localparam int COUNT_W = 6;

   // default size limits
   localparam int MAX_WIDTH_DEF  = 4096;
   localparam int MAX_HEIGHT_DEF = 4096;

   // run marker test and count mask
   localparam logic [BYTE_W-1:0]  RUN_MARK = 8'hC0;
   localparam logic [COUNT_W-1:0] RUN_MASK = 6'h3F;

   // configuration register indexes
   localparam logic [1:0] REG_IMAGE_WIDTH    = 2'd0;
   localparam logic [1:0] REG_IMAGE_HEIGHT   = 2'd1;
   localparam logic [1:0] REG_BYTES_PER_LINE = 2'd2;
   localparam logic [1:0] REG_RGB_MODE       = 2'd3;

   // configuration register contents
   typedef struct packed {
      logic [CFG_W-1:0] image_width;
      logic [CFG_W-1:0] image_height;
      logic [CFG_W-1:0] bytes_per_line;
      logic             rgb_mode;
   } cfg_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic step;
      logic flush;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic has_work;
      logic step_emit;
      logic step_end;
      logic hold_valid;
      logic out_free;
   } status_type;

endpackage

// ===== rtl/pcx_rle_scanline_decoder_core.sv =====
// top level of the pcx run-length scanline decoder
//
//  channel  direction  transfer                 payload
//  req      in         req_tvalid & req_tready  tdata: data_byte, tuser: start_of_image
//  rsp      out        rsp_tvalid & rsp_tready  tdata: address, value; tlast; tuser: done
//  csr      in         psel & penable & pwrite  four 13/1-bit registers at 4*i
//
//  a literal byte is accepted, iterated once, and then its held result is flushed
//  a run marker is only accepted; its value byte is accepted, iterated up to count times,
//  and flushed, one output byte per visible column per cycle unless rsp stalls, set by the
//  single position/address unit; padding columns and truncated runs cost only their iterations
//  reset is synchronous, active high, and clears all state but the payload registers at once
//  a stalled rsp channel stalls iterations only when a result must move out
module pcx_rle_scanline_decoder_core #(
   parameter int MAX_WIDTH  = pcxrle_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = pcxrle_pkg::MAX_HEIGHT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [0:0]  req_tuser,   // [0] start_of_image
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [25:0] pixel_address, [33:26] pixel_value, zero above
   output logic        rsp_tlast,   // last_of_run
   output logic [0:0]  rsp_tuser,   // [0] image_done
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import pcxrle_pkg::*;

   cfg_type           cfg;
   cmd_type           cmd;
   status_type        status;
   logic [ADDR_W-1:0] rsp_address;
   logic [BYTE_W-1:0] rsp_value;
   logic              rsp_done;

   pcxrle_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   pcxrle_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   pcxrle_dp #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .cmd            (cmd),
      .status         (status),
      .start_of_image (req_tuser[0]),
      .data_byte      (req_tdata),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .rsp_address    (rsp_address),
      .rsp_value      (rsp_value),
      .rsp_last       (rsp_tlast),
      .rsp_done       (rsp_done)
   );

   // result packing
   assign rsp_tdata = {6'd0, rsp_value, rsp_address};
   assign rsp_tuser = rsp_done;

`ifndef SYNTHESIS
   // the result that completes the image is always the final one of its byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tlast)
      else $error("image_done result without last_of_run");

   // nothing may remain held while a new byte can be taken
   assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !status.hold_valid)
      else $error("held result left behind while idle");

   // a byte that causes no iteration leaves the controller ready
   assert property (@(posedge clock) disable iff (reset)
      cmd.accept && !status.has_work |=> req_tready)
      else $error("controller left idle for a byte without work");

   // a held result is never moved over an output that was not taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && rsp_tvalid)
      else $error("pending result overwritten");
`endif

endmodule

// ===== rtl/pcxrle_csr.sv =====
// configuration registers behind the apb-style port
module pcxrle_csr (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [3:0]              csr_paddr,
   input  logic [31:0]             csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready,
   output pcxrle_pkg::cfg_type     cfg
);
   import pcxrle_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (csr_paddr[3:2])
            REG_IMAGE_WIDTH:    cfg_in.image_width    = csr_pwdata[CFG_W-1:0];
            REG_IMAGE_HEIGHT:   cfg_in.image_height   = csr_pwdata[CFG_W-1:0];
            REG_BYTES_PER_LINE: cfg_in.bytes_per_line = csr_pwdata[CFG_W-1:0];
            REG_RGB_MODE:       cfg_in.rgb_mode       = csr_pwdata[0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width    <= CFG_W'(1);
         cfg_ff.image_height   <= CFG_W'(1);
         cfg_ff.bytes_per_line <= CFG_W'(1);
         cfg_ff.rgb_mode       <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux
   always_comb begin
      unique case (csr_paddr[3:2])
         REG_IMAGE_WIDTH:    csr_prdata = 32'(cfg_ff.image_width);
         REG_IMAGE_HEIGHT:   csr_prdata = 32'(cfg_ff.image_height);
         REG_BYTES_PER_LINE: csr_prdata = 32'(cfg_ff.bytes_per_line);
         REG_RGB_MODE:       csr_prdata = 32'(cfg_ff.rgb_mode);
         default:            csr_prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/pcxrle_ctrl.sv =====
// controller: sequences accept, per-byte run iterations and final flush
module pcxrle_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  pcxrle_pkg::status_type status,
   output pcxrle_pkg::cmd_type    cmd
);
   import pcxrle_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_ITER  = 3'b010,
      ST_FLUSH = 3'b100
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;

   // command decode
   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      cmd.accept = (state_ff == ST_IDLE) & req_tvalid;
      // a step that pushes the held result needs room in the output register
      cmd.step   = (state_ff == ST_ITER) &
                   (~(status.step_emit & status.hold_valid) | status.out_free);
      cmd.flush  = (state_ff == ST_FLUSH) & (~status.hold_valid | status.out_free);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.accept && status.has_work) state_in = ST_ITER;
         end
         ST_ITER: begin
            if (cmd.step && status.step_end) state_in = ST_FLUSH;
         end
         ST_FLUSH: begin
            if (cmd.flush) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/pcxrle_dp.sv =====
// datapath: run decode, position counters, address generation, result registers
module pcxrle_dp #(
   parameter int MAX_WIDTH  = pcxrle_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = pcxrle_pkg::MAX_HEIGHT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  pcxrle_pkg::cfg_type                 cfg,
   input  pcxrle_pkg::cmd_type                 cmd,
   output pcxrle_pkg::status_type              status,
   input  logic                                start_of_image,
   input  logic [pcxrle_pkg::BYTE_W-1:0]       data_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [pcxrle_pkg::ADDR_W-1:0]       rsp_address,
   output logic [pcxrle_pkg::BYTE_W-1:0]       rsp_value,
   output logic                                rsp_last,
   output logic                                rsp_done
);
   import pcxrle_pkg::*;

   localparam int CW  = $clog2(MAX_WIDTH) + 1;
   localparam int LW  = $clog2(MAX_HEIGHT) + 1;
   localparam int DWW = (CW > CFG_W) ? CW : CFG_W;
   localparam int DWH = (LW > CFG_W) ? LW : CFG_W;

   // decoder state
   logic               run_pending_ff, run_pending_in;
   logic [COUNT_W-1:0] run_length_ff, run_length_in;
   logic [CW-1:0]      column_ff, column_in;
   logic [1:0]         plane_ff, plane_in;
   logic [LW-1:0]      line_count_ff, line_count_in;
   logic [ADDR_W-1:0]  line_base_ff, line_base_in;
   logic               finished_ff, finished_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [BYTE_W-1:0]  byte_ff, byte_in;

   // held result waiting to learn whether it closes the item
   logic               hold_valid_ff, hold_valid_in;
   logic [ADDR_W-1:0]  hold_addr_ff, hold_addr_in;
   logic [BYTE_W-1:0]  hold_value_ff, hold_value_in;
   logic               hold_done_ff, hold_done_in;

   // output register
   logic               out_valid_ff, out_valid_in;
   logic [ADDR_W-1:0]  out_addr_ff, out_addr_in;
   logic [BYTE_W-1:0]  out_value_ff, out_value_in;
   logic               out_last_ff, out_last_in;
   logic               out_done_ff, out_done_in;

   // clamped register values
   logic [DWW-1:0] w_raw, b_raw;
   logic [DWH-1:0] h_raw;
   logic [CW-1:0]  width_c, bpl_c, kept_c;
   logic [LW-1:0]  height_c;

   always_comb begin
      w_raw = DWW'(cfg.image_width);
      b_raw = DWW'(cfg.bytes_per_line);
      h_raw = DWH'(cfg.image_height);
      if (w_raw == '0)                 width_c = CW'(1);
      else if (w_raw > DWW'(MAX_WIDTH)) width_c = CW'(MAX_WIDTH);
      else                             width_c = w_raw[CW-1:0];
      if (b_raw == '0)                 bpl_c = CW'(1);
      else if (b_raw > DWW'(MAX_WIDTH)) bpl_c = CW'(MAX_WIDTH);
      else                             bpl_c = b_raw[CW-1:0];
      if (h_raw == '0)                  height_c = LW'(1);
      else if (h_raw > DWH'(MAX_HEIGHT)) height_c = LW'(MAX_HEIGHT);
      else                              height_c = h_raw[LW-1:0];
      kept_c = (width_c < bpl_c) ? width_c : bpl_c;
   end

   // per-iteration position logic
   logic              is_mark, fin_eff, pend_eff;
   logic              last_plane, last_line, emit, wrap, line_end, step_end;
   logic [CW-1:0]     col_inc;
   logic [LW-1:0]     line_inc;
   logic [CW+1:0]     col3, offset, w_step;
   logic [ADDR_W-1:0] step_addr;
   logic              step_done;

   always_comb begin
      is_mark    = (data_byte & RUN_MARK) == RUN_MARK;
      fin_eff    = finished_ff & ~start_of_image;
      pend_eff   = run_pending_ff & ~start_of_image;
      last_plane = ~cfg.rgb_mode | (plane_ff >= 2'd2);
      line_inc   = line_count_ff + LW'(1);
      last_line  = line_inc >= height_c;
      col_inc    = column_ff + CW'(1);
      emit       = column_ff < width_c;
      wrap       = col_inc >= bpl_c;
      line_end   = wrap & last_plane;
      step_end   = (count_ff == COUNT_W'(1)) | line_end;
      col3       = ({2'b00, column_ff} << 1) + {2'b00, column_ff};
      offset     = cfg.rgb_mode ? (col3 + (CW+2)'(plane_ff)) : {2'b00, column_ff};
      w_step     = cfg.rgb_mode ? (({2'b00, width_c} << 1) + {2'b00, width_c})
                                : {2'b00, width_c};
      step_addr  = line_base_ff + ADDR_W'(offset);
      step_done  = last_plane & last_line & (col_inc == kept_c);
   end

   // decoder state update
   always_comb begin
      run_pending_in = run_pending_ff;
      run_length_in  = run_length_ff;
      column_in      = column_ff;
      plane_in       = plane_ff;
      line_count_in  = line_count_ff;
      line_base_in   = line_base_ff;
      finished_in    = finished_ff;
      count_in       = count_ff;
      byte_in        = byte_ff;

      if (cmd.accept) begin
         byte_in = data_byte;
         // start of image clears the run and position state first
         if (start_of_image) begin
            run_pending_in = 1'b0;
            run_length_in  = '0;
            column_in      = '0;
            plane_in       = '0;
            line_count_in  = '0;
            line_base_in   = '0;
            finished_in    = 1'b0;
         end
         if (!fin_eff) begin
            if (pend_eff) begin
               run_pending_in = 1'b0;
               count_in       = run_length_ff;
            end else if (is_mark) begin
               run_pending_in = 1'b1;
               run_length_in  = data_byte[COUNT_W-1:0] & RUN_MASK;
            end else begin
               count_in = COUNT_W'(1);
            end
         end
      end

      if (cmd.step) begin
         count_in  = count_ff - COUNT_W'(1);
         column_in = col_inc;
         if (wrap) begin
            column_in = '0;
            if (last_plane) begin
               plane_in      = '0;
               line_count_in = line_inc;
               line_base_in  = line_base_ff + ADDR_W'(w_step);
               if (last_line) finished_in = 1'b1;
            end else begin
               plane_in = plane_ff + 2'd1;
            end
         end
      end
   end

   // hold and output registers
   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_addr_in  = hold_addr_ff;
      hold_value_in = hold_value_ff;
      hold_done_in  = hold_done_ff;
      out_addr_in   = out_addr_ff;
      out_value_in  = out_value_ff;
      out_last_in   = out_last_ff;
      out_done_in   = out_done_ff;
      out_valid_in  = out_valid_ff & ~rsp_ready;

      // an earlier held result is pushed out, marked last of its item only on flush
      if ((cmd.step && emit && hold_valid_ff) || (cmd.flush && hold_valid_ff)) begin
         out_valid_in = 1'b1;
         out_addr_in  = hold_addr_ff;
         out_value_in = hold_value_ff;
         out_done_in  = hold_done_ff;
         out_last_in  = cmd.flush;
      end

      if (cmd.step && emit) begin
         hold_valid_in = 1'b1;
         hold_addr_in  = step_addr;
         hold_value_in = byte_ff;
         hold_done_in  = step_done;
      end else if (cmd.flush) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_pending_ff <= 1'b0;
         run_length_ff  <= '0;
         column_ff      <= '0;
         plane_ff       <= '0;
         line_count_ff  <= '0;
         line_base_ff   <= '0;
         finished_ff    <= 1'b0;
         count_ff       <= '0;
         hold_valid_ff  <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         run_pending_ff <= run_pending_in;
         run_length_ff  <= run_length_in;
         column_ff      <= column_in;
         plane_ff       <= plane_in;
         line_count_ff  <= line_count_in;
         line_base_ff   <= line_base_in;
         finished_ff    <= finished_in;
         count_ff       <= count_in;
         hold_valid_ff  <= hold_valid_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      byte_ff       <= byte_in;
      hold_addr_ff  <= hold_addr_in;
      hold_value_ff <= hold_value_in;
      hold_done_ff  <= hold_done_in;
      out_addr_ff   <= out_addr_in;
      out_value_ff  <= out_value_in;
      out_last_ff   <= out_last_in;
      out_done_ff   <= out_done_in;
   end

   // status to controller
   always_comb begin
      status.has_work   = ~fin_eff & (pend_eff ? (run_length_ff != '0) : ~is_mark);
      status.step_emit  = emit;
      status.step_end   = step_end;
      status.hold_valid = hold_valid_ff;
      status.out_free   = ~out_valid_ff | rsp_ready;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_address = out_addr_ff;
   assign rsp_value   = out_value_ff;
   assign rsp_last    = out_last_ff;
   assign rsp_done    = out_done_ff;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// testbench for the pcx run-length scanline decoder: pixel predictor, scoreboard and stream drivers
module tb;
   import pcxrle_pkg::*;

   localparam int unsigned ITEM_TARGET  = 470;
   localparam int unsigned DRAIN_CYCLES = 80;
   localparam int unsigned HOLD_CYCLES  = 300;

   // one decoded byte as it should leave the block
   typedef struct packed {
      logic [ADDR_W-1:0] address;
      logic [BYTE_W-1:0] value;
      logic              last_of_run;
      logic              image_done;
   } pixel_write_type;

   // tracks decoder position and the pixel writes still owed by the block
   class pcx_pixel_tracker;
      logic [CFG_W-1:0]   width_reg;
      logic [CFG_W-1:0]   height_reg;
      logic [CFG_W-1:0]   bpl_reg;
      logic               rgb_reg;
      bit                 run_pending;
      logic [COUNT_W-1:0] run_length;
      int unsigned        column;
      int unsigned        plane_index;
      int unsigned        line_count;
      logic [ADDR_W-1:0]  line_base;
      bit                 finished;
      pixel_write_type    expected_q[$];
      int unsigned        errors;
      int unsigned        pixels_seen;

      function new();
         width_reg   = CFG_W'(1);
         height_reg  = CFG_W'(1);
         bpl_reg     = CFG_W'(1);
         rgb_reg     = 1'b0;
         errors      = 0;
         pixels_seen = 0;
         clear_position();
      endfunction

      function void clear_position();
         run_pending = 1'b0;
         run_length  = '0;
         column      = 0;
         plane_index = 0;
         line_count  = 0;
         line_base   = '0;
         finished    = 1'b0;
      endfunction

      function void set_register(logic [1:0] index, logic [31:0] value);
         case (index)
            REG_IMAGE_WIDTH:    width_reg  = value[CFG_W-1:0];
            REG_IMAGE_HEIGHT:   height_reg = value[CFG_W-1:0];
            REG_BYTES_PER_LINE: bpl_reg    = value[CFG_W-1:0];
            REG_RGB_MODE:       rgb_reg    = value[0];
            default: ;
         endcase
      endfunction

      // zero acts as one, anything above the limit acts as the limit
      function int unsigned dim(logic [CFG_W-1:0] v, int unsigned lim);
         if (v == 0)
            return 1;
         return (v > lim) ? lim : v;
      endfunction

      // encoded bytes still needed to close the current line
      function int unsigned bytes_to_line_end();
         int unsigned bpl;
         int unsigned planes;
         int unsigned rest;
         bpl    = dim(bpl_reg, MAX_WIDTH_DEF);
         planes = rgb_reg ? 3 : 1;
         rest   = (column >= bpl) ? 1 : bpl - column;
         if (plane_index + 1 < planes)
            rest += (planes - 1 - plane_index) * bpl;
         return rest;
      endfunction

      // returns 0 when the byte is ignored after the final line
      function bit take_byte(bit sof, logic [7:0] data);
         int unsigned     count;
         int unsigned     w;
         int unsigned     h;
         int unsigned     bpl;
         int unsigned     planes;
         int unsigned     kept;
         int unsigned     address;
         bit              last_plane;
         bit              last_line;
         pixel_write_type px;
         pixel_write_type batch[$];
         if (sof)
            clear_position();
         if (finished)
            return 1'b0;
         if (run_pending) begin
            run_pending = 1'b0;
            count       = run_length;
         end else if ((data & RUN_MARK) == RUN_MARK) begin
            run_pending = 1'b1;
            run_length  = data[COUNT_W-1:0] & RUN_MASK;
            return 1'b1;
         end else begin
            count = 1;
         end
         w      = dim(width_reg, MAX_WIDTH_DEF);
         h      = dim(height_reg, MAX_HEIGHT_DEF);
         bpl    = dim(bpl_reg, MAX_WIDTH_DEF);
         planes = rgb_reg ? 3 : 1;
         kept   = (w < bpl) ? w : bpl;
         for (int i = 0; i < count; i++) begin
            last_plane = (plane_index + 1 >= planes);
            last_line  = (line_count + 1 >= h);
            if (column < w) begin
               address = rgb_reg ? line_base + column * 3 + plane_index : line_base + column;
               px.address     = address[ADDR_W-1:0];
               px.value       = data;
               px.last_of_run = 1'b0;
               px.image_done  = last_plane && last_line && (column + 1 == kept);
               batch.push_back(px);
            end
            column++;
            if (column >= bpl) begin
               column = 0;
               if (last_plane) begin
                  // line closed: the rest of the run is dropped
                  plane_index = 0;
                  line_count++;
                  line_base = ADDR_W'(line_base + w * planes);
                  if (line_count >= h)
                     finished = 1'b1;
                  break;
               end
               plane_index++;
            end
         end
         if (batch.size() > 0)
            batch[batch.size()-1].last_of_run = 1'b1;
         foreach (batch[k])
            expected_q.push_back(batch[k]);
         return 1'b1;
      endfunction

      function void compare_field(string label, logic [31:0] want_v, logic [31:0] got_v);
         if (got_v !== want_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want_v, got_v);
            errors++;
         end
      endfunction

      function void check_pixel(logic [39:0] tdata, logic tlast, logic done);
         pixel_write_type want;
         pixels_seen++;
         if (expected_q.size() == 0) begin
            $display("%0t: pixel write with nothing expected, expected none, actual address %0h value %0h",
                     $time, tdata[25:0], tdata[33:26]);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         compare_field("pixel_address", 32'(want.address), 32'(tdata[25:0]));
         compare_field("pixel_value", 32'(want.value), 32'(tdata[33:26]));
         compare_field("tdata padding", 32'd0, 32'(tdata[39:34]));
         compare_field("last_of_run", 32'(want.last_of_run), 32'(tlast));
         compare_field("image_done", 32'(want.image_done), 32'(done));
      endfunction
   endclass

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = '0;   // [7:0] data_byte
   logic [0:0]  req_tuser   = '0;   // [0] start_of_image
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [39:0] rsp_tdata;         // [25:0] pixel_address, [33:26] pixel_value, zero above
   logic        rsp_tlast;
   logic [0:0]  rsp_tuser;         // [0] image_done
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [3:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   pcx_pixel_tracker tracker = new();

   int unsigned burst_left      = 0;
   int unsigned accepted_bytes  = 0;
   int unsigned decoded_bytes   = 0;
   int unsigned settings_written = 0;
   int unsigned hold_request    = 0;
   int unsigned hold_left       = 0;
   int unsigned stall_mode      = 0;
   int unsigned mode_cycles     = 0;

   pcx_rle_scanline_decoder_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result side: check each transfer, then pick the next ready level
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         tracker.check_pixel(rsp_tdata, rsp_tlast, rsp_tuser[0]);
      if (hold_left == 0 && hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (mode_cycles == 0) begin
         stall_mode  = $urandom_range(0, 3);
         mode_cycles = $urandom_range(16, 80);
      end else begin
         mode_cycles--;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(0, 1));
            2: rsp_tready <= (mode_cycles % 4 != 0);
            default: rsp_tready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   // hard stop in case the block hangs
   initial begin
      #20_000_000;
      $display("Some tests failed");
      $finish;
   end

   // one input transfer, with bursts and random gaps in between
   task automatic send_byte(input bit sof, input logic [7:0] data);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 12);
         gap        = $urandom_range(0, 4);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= sof;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      accepted_bytes++;
      if (tracker.take_byte(sof, data))
         decoded_bytes++;
   endtask

   task automatic send_run(input bit sof, input logic [5:0] count, input logic [7:0] value);
      send_byte(sof, {2'b11, count});
      send_byte(1'b0, value);
   endtask

   // stop offering input until every pixel write is in, then let trailing work settle
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (tracker.expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // register write followed by a read back of the same register
   task automatic write_register(input logic [1:0] index, input logic [31:0] value);
      logic [31:0] keep_mask;
      logic [31:0] stored;
      keep_mask = (index == REG_RGB_MODE) ? 32'h1 : 32'h1FFF;
      stored    = value & keep_mask;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= stored | ($urandom() & ~keep_mask);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      tracker.set_register(index, stored);
      settings_written++;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== stored) begin
         $display("%0t: register %0d read back mismatch, expected %0h, actual %0h",
                  $time, index, stored, csr_prdata);
         tracker.errors++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_geometry(input int unsigned w, input int unsigned h,
                               input int unsigned bpl, input bit rgb);
      write_register(REG_IMAGE_WIDTH, w);
      write_register(REG_IMAGE_HEIGHT, h);
      write_register(REG_BYTES_PER_LINE, bpl);
      write_register(REG_RGB_MODE, 32'(rgb));
   endtask

   // mostly well-formed literal and run traffic, some noise and broken pairs
   task automatic send_stream(input int unsigned n, input bit fresh);
      int unsigned goal;
      int unsigned pick;
      int unsigned count;
      bit          sof;
      goal = decoded_bytes + n;
      sof  = fresh;
      while (decoded_bytes < goal) begin
         if (tracker.finished && !sof) begin
            if ($urandom_range(0, 4) == 0) begin
               send_byte(1'b0, 8'($urandom_range(0, 255)));
               continue;
            end
            sof = 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            send_byte(sof | ($urandom_range(0, 15) == 0), 8'($urandom_range(0, 255)));
         end else if (pick < 50) begin
            send_byte(sof, 8'($urandom_range(0, 191)));
         end else begin
            case ($urandom_range(0, 9))
               0, 1, 2: count = $urandom_range(1, 4);
               3, 4, 5: count = $urandom_range(0, 63);
               6, 7, 8: count = tracker.bytes_to_line_end();
               default: count = 0;
            endcase
            if (count > 63)
               count = 63;
            send_byte(sof, {2'b11, count[5:0]});
            send_byte($urandom_range(0, 31) == 0, 8'($urandom_range(0, 255)));
         end
         sof = 1'b0;
      end
   endtask

   initial begin
      int unsigned phase;
      int unsigned b;
      bit          fresh;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset geometry: a one pixel image
      send_byte(1'b1, 8'h42);
      wait_idle();

      // indexed plane, two padding columns, two lines
      set_geometry(4, 2, 6, 0);
      send_byte(1'b1, 8'h00);
      send_run(1'b0, 6'd0, 8'hFF);     // zero count consumes its value
      send_run(1'b0, 6'd2, 8'hFF);
      send_byte(1'b0, 8'h7F);
      send_byte(1'b0, 8'hBF);          // padding only
      send_byte(1'b0, 8'h80);
      send_run(1'b0, 6'd63, 8'hC0);    // truncated at line end, image done
      send_byte(1'b0, 8'h55);          // past the last line
      send_byte(1'b0, 8'hC5);
      wait_idle();

      // three planes interleaved, run crossing a plane boundary
      set_geometry(2, 1, 3, 1);
      send_byte(1'b1, 8'h01);
      send_run(1'b0, 6'd4, 8'h12);
      send_run(1'b0, 6'd63, 8'hAA);
      wait_idle();

      // fewer bytes per line than pixels
      set_geometry(5, 1, 3, 0);
      send_byte(1'b1, 8'h10);
      send_byte(1'b0, 8'h20);
      send_byte(1'b0, 8'h30);
      wait_idle();

      // widest line with all-ones and zero registers
      set_geometry(8191, 0, 8191, 0);
      send_run(1'b1, 6'd63, 8'($urandom_range(0, 255)));
      while (!tracker.finished)
         send_run(1'b0, 6'd63, 8'($urandom_range(0, 255)));
      wait_idle();

      // random phases
      phase = 0;
      while (decoded_bytes < ITEM_TARGET) begin
         fresh = 1'b1;
         case ((phase < 5) ? phase : $urandom_range(0, 4))
            0: begin
               b = $urandom_range(1, 16);
               set_geometry(b, $urandom_range(1, 4), b + $urandom_range(0, 4),
                            1'($urandom_range(0, 1)));
            end
            1: begin
               b = $urandom_range(1, 8);
               set_geometry(b + $urandom_range(1, 12), $urandom_range(1, 3), b,
                            1'($urandom_range(0, 1)));
            end
            2: set_geometry($urandom_range(0, 1) ? 0 : $urandom_range(1, 6),
                            $urandom_range(0, 1) ? 0 : $urandom_range(1, 3),
                            $urandom_range(0, 1) ? 0 : $urandom_range(1, 8),
                            1'($urandom_range(0, 1)));
            3: set_geometry($urandom_range(4097, 8191),
                            $urandom_range(0, 1) ? $urandom_range(4097, 8191) : $urandom_range(1, 3),
                            $urandom_range(1, 12), 1'($urandom_range(0, 1)));
            default: begin
               // change one register in mid-image
               fresh = 1'b0;
               if ($urandom_range(0, 1))
                  write_register(REG_IMAGE_HEIGHT, $urandom_range(1, 6));
               else
                  write_register(REG_IMAGE_WIDTH, $urandom_range(1, 12));
            end
         endcase
         // long receiver hold while input keeps coming
         if (phase == 2)
            hold_request = HOLD_CYCLES;
         send_stream($urandom_range(15, 40), fresh);
         // sender pause until the block has drained
         if (phase == 1 || $urandom_range(0, 3) == 0) begin
            wait_idle();
            send_stream(10, 1'b0);
         end
         wait_idle();
         phase++;
      end

      if (tracker.expected_q.size() != 0)
         $display("%0t: %0d pixel writes never arrived", $time, tracker.expected_q.size());
      $display("covered %0d input bytes (%0d decoded) and %0d pixel writes over %0d phases",
               accepted_bytes, decoded_bytes, tracker.pixels_seen, phase);
      $display("%0d register writes, zero and all-ones values and both plane modes among them",
               settings_written);
      if (tracker.errors == 0 && tracker.expected_q.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
